@@ rtl/h2s_pkg.sv @@
// Package for the HDR pixel to sRGB8 converter: item types, format codes,
// pipeline sizes and the sRGB threshold table built at elaboration.
// No dependencies.
package h2s_pkg;

  localparam int MANTISSA_BITS = 24;
  localparam int FRAC_BITS     = 24;
  localparam int QBITS         = FRAC_BITS + 1;
  localparam int VW            = FRAC_BITS + 1;
  localparam int DW            = MANTISSA_BITS + 27;
  localparam int SEARCH_STG    = 8;
  localparam int LANE_STG      = 3 + QBITS + 1 + SEARCH_STG;
  localparam int NSTG          = LANE_STG + 2;

  localparam logic [7:0] OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    FMT_RGBA8      = 3'd0,
    FMT_BGRA8      = 3'd1,
    FMT_RGB10A2    = 3'd2,
    FMT_RGBA16F    = 3'd3,
    FMT_RGBA32F    = 3'd4,
    FMT_R11G11B10F = 3'd5
  } fmt_t;

  typedef enum logic [1:0] {
    K_FIN  = 2'd0,
    K_ZERO = 2'd1,
    K_SAT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [63:0] pixel_low;
    logic [63:0] pixel_high;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_item_t;

  // One float channel in a common form: the mantissa is left aligned to 23 bits.
  typedef struct packed {
    logic        sgn;
    logic        wide;
    logic [7:0]  ex;
    logic [22:0] man;
  } chan_t;

  typedef struct packed {
    logic       hdr;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } byp_t;

  function automatic logic [63:0] pow5_q30(input logic [63:0] c);
    logic [63:0] p;
    p = c;
    for (int i = 0; i < 4; i++) begin
      p = (p * c) >> 30;
    end
    return p;
  endfunction

  // Entry k holds the smallest Q1.24 value that encodes to sRGB code k.
  function automatic logic [256*VW-1:0] srgb_thr_tab();
    logic [256*VW-1:0] tab;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] y;
    logic [63:0] c;
    tab = '0;
    for (int k = 1; k < 256; k++) begin
      if (k <= 10) begin
        t = ((64'(20 * k - 10) << 24) + 64'd65891) / 64'd65892;
      end else begin
        a  = 64'(1000 * k + 13525);
        q  = (a << 30) / 64'd269025;
        q2 = (q * q) >> 30;
        y  = '0;
        for (int b = 29; b >= 0; b--) begin
          c = y | (64'd1 << b);
          if (pow5_q30(c) <= q2) begin
            y = c;
          end
        end
        t = (((q2 * y) >> 30) + 64'd63) >> 6;
      end
      tab[k*VW +: VW] = VW'(t);
    end
    return tab;
  endfunction

  localparam logic [256*VW-1:0] SRGB_THR = srgb_thr_tab();

endpackage

@@ rtl/h2s_unpack.sv @@
// First pipeline stage: splits a raw pixel into three float channels and
// computes the 8-bit and 10-bit pass-through results. Depends on h2s_pkg.
module h2s_unpack import h2s_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [2:0]     fmt,
  input  in_item_t       pix,
  output chan_t [2:0]    ch_r,
  output byp_t           byp_r
);

  localparam logic [17:0] UNORM_HALF = 18'd511;
  localparam logic [17:0] UNORM_MAX  = 18'd1023;

  chan_t [2:0] ch_nxt;
  byp_t        byp_nxt;
  logic [31:0] w;
  logic [63:0] lo;

  function automatic logic [7:0] unorm10(input logic [9:0] c);
    logic [17:0] x;
    logic [7:0]  q0;
    logic [17:0] rem;
    x   = {c, 8'b0} - 18'(c) + UNORM_HALF;
    q0  = x[17:10];
    rem = x - ({q0, 10'b0} - 18'(q0));
    return (rem >= UNORM_MAX) ? q0 + 8'd1 : q0;
  endfunction

  assign lo = pix.pixel_low;
  assign w  = lo[31:0];

  always_comb begin
    ch_nxt  = '0;
    byp_nxt = '0;
    unique case (fmt)
      FMT_RGBA8: begin
        byp_nxt.r = w[7:0];
        byp_nxt.g = w[15:8];
        byp_nxt.b = w[23:16];
      end
      FMT_BGRA8: begin
        byp_nxt.b = w[7:0];
        byp_nxt.g = w[15:8];
        byp_nxt.r = w[23:16];
      end
      FMT_RGB10A2: begin
        byp_nxt.r = unorm10(w[9:0]);
        byp_nxt.g = unorm10(w[19:10]);
        byp_nxt.b = unorm10(w[29:20]);
      end
      FMT_RGBA16F: begin
        byp_nxt.hdr = 1'b1;
        ch_nxt[0] = '{sgn: lo[15], wide: 1'b0, ex: {3'b0, lo[14:10]}, man: {lo[9:0], 13'b0}};
        ch_nxt[1] = '{sgn: lo[31], wide: 1'b0, ex: {3'b0, lo[30:26]}, man: {lo[25:16], 13'b0}};
        ch_nxt[2] = '{sgn: lo[47], wide: 1'b0, ex: {3'b0, lo[46:42]}, man: {lo[41:32], 13'b0}};
      end
      FMT_RGBA32F: begin
        byp_nxt.hdr = 1'b1;
        ch_nxt[0] = '{sgn: lo[31], wide: 1'b1, ex: lo[30:23], man: lo[22:0]};
        ch_nxt[1] = '{sgn: lo[63], wide: 1'b1, ex: lo[62:55], man: lo[54:32]};
        ch_nxt[2] = '{sgn: pix.pixel_high[31], wide: 1'b1, ex: pix.pixel_high[30:23],
                      man: pix.pixel_high[22:0]};
      end
      FMT_R11G11B10F: begin
        byp_nxt.hdr = 1'b1;
        ch_nxt[0] = '{sgn: 1'b0, wide: 1'b0, ex: {3'b0, w[10:6]}, man: {w[5:0], 17'b0}};
        ch_nxt[1] = '{sgn: 1'b0, wide: 1'b0, ex: {3'b0, w[21:17]}, man: {w[16:11], 17'b0}};
        ch_nxt[2] = '{sgn: 1'b0, wide: 1'b0, ex: {3'b0, w[31:27]}, man: {w[26:22], 18'b0}};
      end
      default: begin
        byp_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r  <= ch_nxt;
      byp_r <= byp_nxt;
    end
  end

endmodule

@@ rtl/h2s_lane.sv @@
// One color channel: float decode, normalize, Reinhard divide one quotient
// bit per stage, round, then sRGB binary search. Depends on h2s_pkg.
module h2s_lane import h2s_pkg::*; (
  input  logic                clk,
  input  logic [LANE_STG-1:0] en,
  input  chan_t               ch,
  output logic [7:0]          code
);

  localparam int MB = MANTISSA_BITS;
  localparam int DS = 3;
  localparam int RS = DS + QBITS;
  localparam int SS = RS + 1;

  // Decode and leading-one search.
  kind_t       s1_kind_r;
  chan_t       s1_ch_r;
  logic [4:0]  s1_p_r;
  kind_t       kind1;
  logic [7:0]  emax;
  logic [4:0]  p1;

  always_comb begin
    emax = ch.wide ? 8'd255 : 8'd31;
    if (ch.ex == emax) begin
      kind1 = (ch.man == '0 && !ch.sgn) ? K_SAT : K_ZERO;
    end else if (ch.sgn || (ch.ex == '0 && ch.man == '0)) begin
      kind1 = K_ZERO;
    end else begin
      kind1 = K_FIN;
    end
    p1 = '0;
    for (int i = 0; i < 23; i++) begin
      if (ch.man[i]) begin
        p1 = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_kind_r <= kind1;
      s1_ch_r   <= ch;
      s1_p_r    <= p1;
    end
  end

  // Normalize to an exponent and an MB-bit mantissa.
  kind_t              s2_kind_r;
  logic signed [9:0]  s2_e_r;
  logic [MB-1:0]      s2_m_r;
  kind_t              kind2;
  logic signed [9:0]  bias;
  logic signed [9:0]  e2;
  logic [23:0]        sig24;
  logic [MB-1:0]      m2;
  logic               sub;

  always_comb begin
    sub  = (s1_ch_r.ex == '0);
    bias = s1_ch_r.wide ? 10'sd127 : 10'sd15;
    if (sub) begin
      e2    = $signed({5'b0, s1_p_r}) - 10'sd22 - bias;
      sig24 = {1'b0, s1_ch_r.man} << (5'd23 - s1_p_r);
    end else begin
      e2    = $signed({2'b0, s1_ch_r.ex}) - bias;
      sig24 = {1'b1, s1_ch_r.man};
    end
    kind2 = s1_kind_r;
    if (s1_kind_r == K_FIN) begin
      if (e2 >= 10'sd26) begin
        kind2 = K_SAT;
      end else if (e2 <= -10'sd27) begin
        kind2 = K_ZERO;
      end
    end
  end

  if (MB >= 24) begin : g_widen
    assign m2 = MB'(sig24) << (MB - 24);
  end else begin : g_narrow
    assign m2 = MB'(sig24 >> (24 - MB));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_kind_r <= kind2;
      s2_e_r    <= e2;
      s2_m_r    <= m2;
    end
  end

  // Divider set-up and quotient stages; entry 0 is the set-up register.
  logic [DW-1:0]    div_rem_r  [QBITS+1];
  logic [DW-1:0]    div_d_r    [QBITS+1];
  logic [QBITS-1:0] div_q_r    [QBITS+1];
  kind_t            div_kind_r [QBITS+1];
  logic signed [9:0] k3;
  logic [5:0]        kneg;
  logic [DW-1:0]     n3;
  logic [DW-1:0]     d3;

  always_comb begin
    k3   = 10'(MB - 1) - s2_e_r;
    kneg = 6'(-k3);
    if (k3 >= 10'sd0) begin
      n3 = DW'(s2_m_r);
      d3 = n3 + (DW'(1) << k3[5:0]);
    end else begin
      n3 = DW'(s2_m_r) << kneg;
      d3 = n3 + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      div_rem_r[0]  <= n3;
      div_d_r[0]    <= d3;
      div_q_r[0]    <= '0;
      div_kind_r[0] <= s2_kind_r;
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_div
    logic [DW:0]   r2;
    logic          take;
    logic [DW-1:0] rem_nxt;

    assign r2      = {div_rem_r[j-1], 1'b0};
    assign take    = (r2 >= {1'b0, div_d_r[j-1]});
    assign rem_nxt = take ? DW'(r2 - {1'b0, div_d_r[j-1]}) : DW'(r2);

    always_ff @(posedge clk) begin
      if (en[DS+j-1]) begin
        div_rem_r[j]  <= rem_nxt;
        div_d_r[j]    <= div_d_r[j-1];
        div_q_r[j]    <= {div_q_r[j-1][QBITS-2:0], take};
        div_kind_r[j] <= div_kind_r[j-1];
      end
    end
  end

  // Rounding, then the search entries; entry 0 is the rounded value.
  logic [VW-1:0] srch_v_r [SEARCH_STG+1];
  logic [7:0]    srch_c_r [SEARCH_STG+1];
  logic [QBITS:0] qr;
  logic [VW-1:0]  v_nxt;

  always_comb begin
    qr = {1'b0, div_q_r[QBITS]} + (QBITS+1)'(1);
    unique case (div_kind_r[QBITS])
      K_ZERO:  v_nxt = '0;
      K_SAT:   v_nxt = VW'(1) << FRAC_BITS;
      default: v_nxt = VW'(qr >> 1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[RS]) begin
      srch_v_r[0] <= v_nxt;
      srch_c_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < SEARCH_STG; s++) begin : g_srch
    logic [7:0] cand;
    logic       hit;

    assign cand = srch_c_r[s] | (8'd1 << (SEARCH_STG - 1 - s));
    assign hit  = (SRGB_THR[VW*int'(cand) +: VW] <= srch_v_r[s]);

    always_ff @(posedge clk) begin
      if (en[SS+s]) begin
        srch_v_r[s+1] <= srch_v_r[s];
        srch_c_r[s+1] <= hit ? cand : srch_c_r[s];
      end
    end
  end

  assign code = srch_c_r[SEARCH_STG];

endmodule

@@ rtl/hdr_pixel_to_srgb8_converter.sv @@
// Top level of the HDR pixel to sRGB8 converter: format register, pipeline
// flow control, three channel lanes and the output register.
// Depends on h2s_pkg, h2s_unpack and h2s_lane.
//
//   Port group   Direction  Handshake           Carries
//   in_*         input      in_valid/in_ready   in_item_t raw pixel
//   out_*        output     out_valid/out_ready out_item_t RGBA8 pixel
//   cfg_*        input      cfg_we              pixel format code
//
// An item passes NSTG (39) register stages and leaves the last one when
// out_ready is high. One item is accepted per cycle unless an output stall
// backs up to in_ready; the 25 one-bit divider stages set the depth.
// A stage takes a new item when it is empty or its item moves on, so bubbles
// close up during an output stall. Reset clears all valid bits and selects
// the rgba8 format.
module hdr_pixel_to_srgb8_converter import h2s_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_pixel,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_pixel,
  input  logic      cfg_we,
  input  logic [2:0] cfg_wdata
);

  logic [2:0]      fmt_r;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGBA8;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  assign rdy[NSTG] = out_ready;
  for (genvar i = 0; i < NSTG; i++) begin : g_flow
    assign rdy[i] = ~vld_r[i] | rdy[i+1];
  end
  assign en = rdy[NSTG-1:0];

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      if (en[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];

  chan_t [2:0] ch;
  byp_t        byp0;

  h2s_unpack u_unpack (
    .clk   (clk),
    .en    (en[0]),
    .fmt   (fmt_r),
    .pix   (in_pixel),
    .ch_r  (ch),
    .byp_r (byp0)
  );

  logic [7:0] code [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    h2s_lane u_lane (
      .clk  (clk),
      .en   (en[LANE_STG:1]),
      .ch   (ch[c]),
      .code (code[c])
    );
  end

  byp_t bypd_r [LANE_STG];

  for (genvar i = 0; i < LANE_STG; i++) begin : g_byp
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        bypd_r[i] <= (i == 0) ? byp0 : bypd_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  out_item_t out_nxt;
  out_item_t out_r;

  always_comb begin
    out_nxt.alpha = OPAQUE;
    if (bypd_r[LANE_STG-1].hdr) begin
      out_nxt.red   = code[0];
      out_nxt.green = code[1];
      out_nxt.blue  = code[2];
    end else begin
      out_nxt.red   = bypd_r[LANE_STG-1].r;
      out_nxt.green = bypd_r[LANE_STG-1].g;
      out_nxt.blue  = bypd_r[LANE_STG-1].b;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_pixel = out_r;

endmodule

@@ test/tb_top.sv @@
// Testbench for hdr_pixel_to_srgb8_converter: directed and random pixels in
// every format, checked against a local bit-exact tone-map and sRGB predictor.
// Depends on h2s_pkg and the converter RTL.
module tb_top;
  import h2s_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FMT_RSVD6 = 3'd6;
  localparam logic [2:0] FMT_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_pixel;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  logic [2:0] cur_format = FMT_RGBA8;
  logic [24:0] srgb_thr [1:255];
  out_item_t pending_pixels[$];
  int mismatches = 0;
  int cycles = 0;
  int out_stall = 0;
  bit burst_mode = 1'b0;

  hdr_pixel_to_srgb8_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel(out_pixel),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] fifth_power(logic [63:0] c);
    logic [63:0] p;
    p = c;
    for (int i = 0; i < 4; i++) p = (p * c) >> 30;
    return p;
  endfunction

  function automatic void build_srgb_thresholds();
    logic [63:0] t, a, q, q2, y, c;
    for (int k = 1; k <= 255; k++) begin
      if (k <= 10) begin
        t = ((64'(20 * k - 10) << 24) + 64'd65891) / 64'd65892;
      end else begin
        a = 64'(1000 * k + 13525);
        q = (a << 30) / 64'd269025;
        q2 = (q * q) >> 30;
        y = '0;
        for (int b = 29; b >= 0; b--) begin
          c = y | (64'd1 << b);
          if (fifth_power(c) <= q2) y = c;
        end
        t = (((q2 * y) >> 30) + 64'd63) >> 6;
      end
      srgb_thr[k] = t[24:0];
    end
  endfunction

  function automatic logic [7:0] srgb_code(logic [63:0] v);
    int cnt;
    cnt = 0;
    if (v == 0) return 8'd0;
    if (v > (64'd1 << 24)) v = 64'd1 << 24;
    for (int k = 1; k <= 255; k++) if (64'(srgb_thr[k]) <= v) cnt++;
    return 8'(cnt);
  endfunction

  function automatic logic [7:0] tonemap_channel(bit s, int ex, int man, int ebits, int mbits);
    int emax, bias, e, p, w, sh;
    logic [63:0] sig, m, num, den, q;
    emax = (1 << ebits) - 1;
    bias = emax >> 1;
    if (ex == emax) return (man == 0 && !s) ? 8'd255 : 8'd0;
    if (s) return 8'd0;
    if (ex == 0) begin
      if (man == 0) return 8'd0;
      p = mbits - 1;
      while (p > 0 && ((man >> p) & 1) == 0) p--;
      sig = 64'(man);
      w = p + 1;
      e = p + 1 - bias - mbits;
    end else begin
      sig = (64'd1 << mbits) | 64'(man);
      w = mbits + 1;
      e = ex - bias;
    end
    m = sig << (24 - w);
    if (e >= 26) begin
      q = 64'd1 << 24;
    end else if (e <= -27) begin
      q = 0;
    end else begin
      sh = 23 - e;
      if (sh >= 0) begin
        num = m << 25;
        den = m + (64'd1 << sh);
      end else begin
        num = (m << (-sh)) << 25;
        den = (m << (-sh)) + 64'd1;
      end
      q = ((num / den) + 64'd1) >> 1;
    end
    return srgb_code(q);
  endfunction

  function automatic logic [7:0] half_to_srgb8(logic [15:0] h);
    return tonemap_channel(h[15], int'(h[14:10]), int'(h[9:0]), 5, 10);
  endfunction

  function automatic logic [7:0] single_to_srgb8(logic [31:0] f);
    return tonemap_channel(f[31], int'(f[30:23]), int'(f[22:0]), 8, 23);
  endfunction

  function automatic logic [7:0] unorm10_to_8(logic [9:0] c);
    return 8'((int'(c) * 255 + 511) / 1023);
  endfunction

  function automatic out_item_t predict_srgb8(in_item_t p, logic [2:0] fmt);
    out_item_t o;
    logic [31:0] w;
    w = p.pixel_low[31:0];
    o = '0;
    o.alpha = OPAQUE;
    case (fmt)
      FMT_RGBA8: begin
        o.red = w[7:0]; o.green = w[15:8]; o.blue = w[23:16];
      end
      FMT_BGRA8: begin
        o.blue = w[7:0]; o.green = w[15:8]; o.red = w[23:16];
      end
      FMT_RGB10A2: begin
        o.red = unorm10_to_8(w[9:0]);
        o.green = unorm10_to_8(w[19:10]);
        o.blue = unorm10_to_8(w[29:20]);
      end
      FMT_RGBA16F: begin
        o.red = half_to_srgb8(p.pixel_low[15:0]);
        o.green = half_to_srgb8(p.pixel_low[31:16]);
        o.blue = half_to_srgb8(p.pixel_low[47:32]);
      end
      FMT_RGBA32F: begin
        o.red = single_to_srgb8(w);
        o.green = single_to_srgb8(p.pixel_low[63:32]);
        o.blue = single_to_srgb8(p.pixel_high[31:0]);
      end
      FMT_R11G11B10F: begin
        o.red = tonemap_channel(1'b0, int'(w[10:6]), int'(w[5:0]), 5, 6);
        o.green = tonemap_channel(1'b0, int'(w[21:17]), int'(w[16:11]), 5, 6);
        o.blue = tonemap_channel(1'b0, int'(w[31:27]), int'(w[26:22]), 5, 5);
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 9))
      0: h[14:0] = '0;
      1: begin h[14:10] = 5'h1F; h[9:0] = '0; end
      2: begin h[14:10] = 5'h1F; h[9:0] = 10'($urandom_range(1, 1023)); end
      3: h[14:10] = '0;
      4: ;
      default: begin h[15] = 1'b0; h[14:10] = 5'($urandom_range(1, 30)); end
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rand_single();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0: f[30:0] = '0;
      1: begin f[30:23] = 8'hFF; f[22:0] = '0; end
      2: begin f[30:23] = 8'hFF; f[22:0] = 23'($urandom_range(1, 32'h7FFFFF)); end
      3: f[30:23] = '0;
      4: ;
      default: begin f[31] = 1'b0; f[30:23] = 8'($urandom_range(127 - 30, 127 + 27)); end
    endcase
    return f;
  endfunction

  function automatic in_item_t rand_pixel(logic [2:0] fmt);
    in_item_t p;
    p.pixel_low = rand64();
    p.pixel_high = rand64();
    case (fmt)
      FMT_RGBA16F: p.pixel_low[47:0] = {rand_half(), rand_half(), rand_half()};
      FMT_RGBA32F: begin
        p.pixel_low = {rand_single(), rand_single()};
        p.pixel_high[31:0] = rand_single();
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic send_pixel(in_item_t p);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_pixel = p;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(predict_srgb8(p, cur_format));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(logic [2:0] fmt);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = fmt;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_format = fmt;
    burst_mode = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_halves(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_item_t p;
    p.pixel_low = {16'($urandom), b, g, r};
    p.pixel_high = rand64();
    send_pixel(p);
  endtask

  task automatic send_singles(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    in_item_t p;
    p.pixel_low = {g, r};
    p.pixel_high = {32'($urandom), b};
    send_pixel(p);
  endtask

  task automatic test_passthrough();
    set_format(FMT_RGBA8);
    send_pixel('{pixel_low: '0, pixel_high: '0});
    send_pixel('{pixel_low: '1, pixel_high: '1});
    set_format(FMT_BGRA8);
    send_pixel('{pixel_low: 64'h0000_0000_00A1_B2C3, pixel_high: '0});
    send_pixel('{pixel_low: '1, pixel_high: '1});
  endtask

  task automatic test_unorm10();
    set_format(FMT_RGB10A2);
    send_pixel('{pixel_low: '0, pixel_high: '0});
    send_pixel('{pixel_low: '1, pixel_high: '1});
    send_pixel('{pixel_low: 64'h0000_0000_0080_2001, pixel_high: '0});
  endtask

  task automatic test_half();
    set_format(FMT_RGBA16F);
    send_halves(16'h0000, 16'h8000, 16'h7C00);
    send_halves(16'hFC00, 16'h7E00, 16'h0001);
    send_halves(16'h03FF, 16'h3C00, 16'h7BFF);
    send_halves(16'hBC00, 16'h0400, 16'h1000);
  endtask

  task automatic test_float32();
    set_format(FMT_RGBA32F);
    send_singles(32'h0000_0000, 32'h8000_0000, 32'h7F80_0000);
    send_singles(32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001);
    send_singles(32'h007F_FFFF, 32'h3F80_0000, 32'h7F7F_FFFF);
    send_singles(32'h4C80_0000, 32'h3280_0000, 32'h4CFF_FFFF);
  endtask

  task automatic test_packed_float();
    set_format(FMT_R11G11B10F);
    send_pixel('{pixel_low: '0, pixel_high: '0});
    send_pixel('{pixel_low: {32'hFFFF_FFFF, 32'hF83E_07C0}, pixel_high: '0});
    send_pixel('{pixel_low: '1, pixel_high: '1});
    send_pixel('{pixel_low: 64'h0000_0000_0040_0801, pixel_high: '0});
  endtask

  task automatic test_reserved_formats();
    set_format(FMT_RSVD6);
    send_pixel('{pixel_low: '1, pixel_high: '1});
    set_format(FMT_RSVD7);
    send_pixel('{pixel_low: rand64(), pixel_high: rand64()});
  endtask

  task automatic test_random_pixels(int total);
    logic [2:0] fmt;
    int n;
    while (total > 0) begin
      fmt = 3'($urandom_range(0, 11) > 8 ? $urandom_range(6, 7) : $urandom_range(0, 5));
      set_format(fmt);
      n = $urandom_range(30, 120);
      if (n > total) n = total;
      repeat (n) send_pixel(rand_pixel(fmt));
      total -= n;
    end
    set_format(FMT_R11G11B10F);
    repeat (20) send_pixel(rand_pixel(FMT_R11G11B10F));
  endtask

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      out_stall = burst_mode ? 0 : $urandom_range(0, 13);
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected item: %h", out_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel.red !== want.red || out_pixel.green !== want.green ||
            out_pixel.blue !== want.blue || out_pixel.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     want.red, want.green, want.blue, want.alpha, out_pixel.red,
                     out_pixel.green, out_pixel.blue, out_pixel.alpha);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    build_srgb_thresholds();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_passthrough();
    test_unorm10();
    test_half();
    test_float32();
    test_packed_float();
    test_reserved_formats();
    test_random_pixels(1850);
    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
